### hdl/dpqa_pkg.sv
package dpqa_pkg;

    // Fixed field widths of the command and result transactions
    localparam int CMD_W    = 3;
    localparam int ID_W     = 8;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes
    localparam cmd_t CMD_ALLOC_CLEAN = 3'd0;
    localparam cmd_t CMD_ALLOC_DIRTY = 3'd1;
    localparam cmd_t CMD_LOOKUP      = 3'd2;
    localparam cmd_t CMD_FREE_CLEAN  = 3'd3;
    localparam cmd_t CMD_FREE_DIRTY  = 3'd4;

    // Status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_UNMAPPED = 2'd2;

endpackage

### hdl/dual_pool_qubit_allocator_top.sv
// Sequence: an accepted command reads the stack memory and the translation
// memory and moves to S_RD, which does the write-back and registers the
// result with out_valid; while out_stall holds the output, the result waits
// in S_HOLD. No overlap between commands: a new one is accepted only in S_IDLE.
// Reset: clean count full, dirty count and output valid clear at once; then a
// clearing pass over all LOGICAL_IDS entries marks every map entry unmapped (in_stall high).
module dual_pool_qubit_allocator_top
    import dpqa_pkg::*;
#(
    parameter int PHYS_SLOTS  = 128,
    parameter int LOGICAL_IDS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [ID_W-1:0]     logical_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SLOT_W-1:0]   physical_slot,
    output logic [STATUS_W-1:0] status
);

    localparam int SW          = $clog2(PHYS_SLOTS);
    localparam int CW          = $clog2(PHYS_SLOTS + 1);
    localparam int IW          = $clog2(LOGICAL_IDS);
    localparam int STACK_DEPTH = 2 * (2 ** SW);
    localparam int ID_SPAN     = 2 ** ID_W;

    localparam logic [CW-1:0] FULL_CNT  = CW'(PHYS_SLOTS);
    localparam logic [SW-1:0] TOP_SLOT  = SW'(PHYS_SLOTS - 1);
    localparam logic [IW-1:0] LAST_ID   = IW'(LOGICAL_IDS - 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    // Id reduction table: logical_id modulo LOGICAL_IDS
    logic [IW-1:0] id_tab [ID_SPAN];
    for (genvar g = 0; g < ID_SPAN; g++) begin : g_id_tab
        assign id_tab[g] = IW'(g % LOGICAL_IDS);
    end

    // Memories: both pools share one stack memory, pool bit on top of address
    logic [SW-1:0] stack_mem [STACK_DEPTH];
    logic [SW:0]   map_mem   [LOGICAL_IDS];

    // Control registers
    logic [1:0]    state_reg,     state_next;
    logic [IW-1:0] clr_cnt_reg,   clr_cnt_next;
    logic [CW-1:0] clean_cnt_reg, clean_cnt_next;
    logic [CW-1:0] dirty_cnt_reg, dirty_cnt_next;
    logic [CW-1:0] lwm_reg,       lwm_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers
    cmd_t          cmd_reg;
    logic [IW-1:0] id_reg;
    logic          pop_ok_reg;
    logic          use_init_reg;
    logic [SW-1:0] init_slot_reg;
    logic [SW-1:0] stack_rd_reg;
    logic [SW:0]   map_rd_reg;
    logic [SLOT_W-1:0] hold_slot_reg;
    status_t           hold_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    status_t           out_status_reg;

    // Memory port controls
    logic                         stack_re, stack_we;
    logic [$clog2(STACK_DEPTH)-1:0] stack_ra, stack_wa;
    logic [SW-1:0]                stack_wd;
    logic                         map_re, map_we;
    logic [IW-1:0]                map_ra, map_wa;
    logic [SW:0]                  map_wd;

    // Issue-side decode
    logic          accept;
    logic          is_alloc;
    logic          pick_dirty;
    logic          pop_ok;
    logic [CW-1:0] pop_cnt;
    logic [CW-1:0] pop_idx;
    logic          use_init;

    // Completion-side decode
    logic          mapped;
    logic [SW-1:0] map_slot;
    logic [SW-1:0] alloc_slot;
    logic [SW-1:0] res_slot;
    status_t       res_status;
    logic [SW+SLOT_W-1:0] slot_ext;
    logic [SLOT_W-1:0]    res_slot_out;
    logic          push_dirty;
    logic [CW-1:0] push_cnt;
    logic          out_free;

    assign in_stall      = (state_reg != S_IDLE);
    assign accept        = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign physical_slot = out_slot_reg;
    assign status        = out_status_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    // Pop selection, done at accept against current counts
    always_comb
    begin
        is_alloc   = (command == CMD_ALLOC_CLEAN) || (command == CMD_ALLOC_DIRTY);
        pick_dirty = (command == CMD_ALLOC_DIRTY) && (dirty_cnt_reg != '0);
        pop_ok     = is_alloc && (pick_dirty || (clean_cnt_reg != '0));
        pop_cnt    = pick_dirty ? dirty_cnt_reg : clean_cnt_reg;
        pop_idx    = pop_cnt - CW'(1);
        // clean entries below the low-water mark were never overwritten
        use_init   = !pick_dirty && (pop_idx < lwm_reg);
    end

    assign stack_re = accept && pop_ok;
    assign stack_ra = {pick_dirty, pop_idx[SW-1:0]};
    assign map_re   = accept;
    assign map_ra   = id_tab[logical_id];

    // Completion: build result and write-back
    always_comb
    begin
        mapped     = map_rd_reg[SW];
        map_slot   = map_rd_reg[SW-1:0];
        alloc_slot = use_init_reg ? init_slot_reg : stack_rd_reg;
        res_slot   = '0;
        res_status = ST_OK;
        push_dirty = (cmd_reg == CMD_FREE_DIRTY);
        push_cnt   = push_dirty ? dirty_cnt_reg : clean_cnt_reg;
        unique case (cmd_reg)
            CMD_ALLOC_CLEAN, CMD_ALLOC_DIRTY:
            begin
                if (pop_ok_reg)
                    res_slot = alloc_slot;
                else
                    res_status = ST_EMPTY;
            end
            CMD_LOOKUP, CMD_FREE_CLEAN, CMD_FREE_DIRTY:
            begin
                if (mapped)
                    res_slot = map_slot;
                else
                    res_status = ST_UNMAPPED;
            end
            default:
            begin
                res_slot   = '0;
                res_status = ST_OK;
            end
        endcase
        slot_ext     = {SLOT_W'(0), res_slot};
        res_slot_out = slot_ext[SLOT_W-1:0];
    end

    // Sequencer and counters
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clean_cnt_next = clean_cnt_reg;
        dirty_cnt_next = dirty_cnt_reg;
        lwm_next       = lwm_reg;
        out_valid_next = out_valid_reg && out_stall;
        stack_we       = 1'b0;
        stack_wa       = {push_dirty, push_cnt[SW-1:0]};
        stack_wd       = map_slot;
        map_we         = 1'b0;
        map_wa         = id_reg;
        map_wd         = {1'b0, map_slot};

        unique case (state_reg)
            S_CLR:
            begin
                map_we       = 1'b1;
                map_wa       = clr_cnt_reg;
                map_wd       = '0;
                clr_cnt_next = clr_cnt_reg + IW'(1);
                if (clr_cnt_reg == LAST_ID)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RD;
                    if (pop_ok)
                    begin
                        if (pick_dirty)
                            dirty_cnt_next = pop_idx;
                        else
                            clean_cnt_next = pop_idx;
                        if (use_init)
                            lwm_next = pop_idx;
                    end
                end
            end
            S_RD:
            begin
                // map and pool write-back
                if ((cmd_reg == CMD_ALLOC_CLEAN || cmd_reg == CMD_ALLOC_DIRTY) && pop_ok_reg)
                begin
                    map_we = 1'b1;
                    map_wd = {1'b1, alloc_slot};
                end
                if ((cmd_reg == CMD_FREE_CLEAN || cmd_reg == CMD_FREE_DIRTY) && mapped)
                begin
                    map_we = 1'b1;
                    if (push_cnt < FULL_CNT)
                    begin
                        stack_we = 1'b1;
                        if (push_dirty)
                            dirty_cnt_next = dirty_cnt_reg + CW'(1);
                        else
                            clean_cnt_next = clean_cnt_reg + CW'(1);
                    end
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clean_cnt_reg <= FULL_CNT;
            dirty_cnt_reg <= '0;
            lwm_reg       <= FULL_CNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clean_cnt_reg <= clean_cnt_next;
            dirty_cnt_reg <= dirty_cnt_next;
            lwm_reg       <= lwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command context captured at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= command;
            id_reg        <= map_ra;
            pop_ok_reg    <= pop_ok;
            use_init_reg  <= use_init;
            init_slot_reg <= TOP_SLOT - pop_idx[SW-1:0];
        end
    end

    // Result and holding registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            if (out_free)
            begin
                out_slot_reg   <= res_slot_out;
                out_status_reg <= res_status;
            end
            else
            begin
                hold_slot_reg   <= res_slot_out;
                hold_status_reg <= res_status;
            end
        end
        else if (state_reg == S_HOLD && out_free)
        begin
            out_slot_reg   <= hold_slot_reg;
            out_status_reg <= hold_status_reg;
        end
    end

    // Stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_wa] <= stack_wd;
        if (stack_re)
            stack_rd_reg <= stack_mem[stack_ra];
    end

    // Translation memory: {mapped, slot}, registered read
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        if (map_re)
            map_rd_reg <= map_mem[map_ra];
    end

endmodule

### hdl/dpqa_checker.sv
module dpqa_checker
    import dpqa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [SLOT_W-1:0]   physical_slot,
    input logic [STATUS_W-1:0] status
);

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(physical_slot) && $stable(status))
        else $error("result changed while stalled");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_UNMAPPED))
        else $error("undefined status code");

    // Failed commands report slot zero
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_UNMAPPED) |-> physical_slot == '0)
        else $error("failed command with nonzero slot");

    // A command occupies the block for the write-back cycle after accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("command accepted during write-back");

endmodule

bind dual_pool_qubit_allocator_top dpqa_checker u_dpqa_checker (.*);
